[rtl/core/alloc_bmp_pkg.sv]
// Shared types and constants for the allocation bitmap block.
package alloc_bmp_pkg;

    localparam int SLOT_BITS     = 64;
    localparam int SLOT_IDX_W    = 6;
    localparam int MAX_SLOTS_DEF = 64;
    localparam int BIT_IDX_W     = 12;
    localparam int CHG_W         = 13;

    localparam logic [SLOT_BITS-1:0] SLOT_ONES = '1;

    typedef enum logic [2:0] {
        KIND_WRITE   = 3'd0,
        KIND_READ    = 3'd1,
        KIND_FIND    = 3'd2,
        KIND_EXPAND  = 3'd3,
        KIND_COMPACT = 3'd4
    } t_kind;

    typedef struct packed {
        logic [2:0]           kind;
        logic [BIT_IDX_W-1:0] bit_index;
        logic                 set_value;
    } t_in_item;

    typedef struct packed {
        logic                 bit_value;
        logic                 found;
        logic [BIT_IDX_W-1:0] found_index;
        logic [CHG_W-1:0]     bits_changed;
        logic                 status;
    } t_out_item;

endpackage

[rtl/core/allocation_bitmap_top.sv]
// Allocation bitmap: slot memory with bit access, first-zero search, expand and compact.
//
//  channel   direction  handshake                        payload
//  input     in         i_in_valid / o_in_stall          i_in_item  (t_in_item)
//  output    out        o_out_valid / i_out_stall        o_out_item (t_out_item)
//
// An in-range bit write or read passes from accept through issue, the slot memory's
// registered read and the done state into the output register. Expand, out-of-range
// accesses and unused kinds go from issue straight to done. Find-first-unset and compact
// add one search step per slot visited. Only one item is in flight, and the next is
// accepted once the block is back in idle after the result is loaded; an output stall
// holds the finished result in the output register. Reset clears state, slot count and valid.
module allocation_bitmap_top #(
    parameter int MAX_SLOTS = alloc_bmp_pkg::MAX_SLOTS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  alloc_bmp_pkg::t_in_item i_in_item,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output alloc_bmp_pkg::t_out_item o_out_item
);

    localparam int AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW   = $clog2(MAX_SLOTS + 1);
    localparam int CMPW = (CW > alloc_bmp_pkg::SLOT_IDX_W) ? CW : alloc_bmp_pkg::SLOT_IDX_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_SLOTS);
    localparam int SB   = alloc_bmp_pkg::SLOT_BITS;
    localparam int SIW  = alloc_bmp_pkg::SLOT_IDX_W;
    localparam int BIW  = alloc_bmp_pkg::BIT_IDX_W;
    localparam int CHW  = alloc_bmp_pkg::CHG_W;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_ISSUE   = 6'b000010,
        S_RW      = 6'b000100,
        S_FIND    = 6'b001000,
        S_COMPACT = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_out_valid, n_out_valid;
    alloc_bmp_pkg::t_out_item r_out_item, n_out_item;
    alloc_bmp_pkg::t_out_item r_res, n_res;
    alloc_bmp_pkg::t_in_item  r_req, n_req;
    logic [AW-1:0]            r_i, n_i;
    logic [CHW-1:0]           r_removed, n_removed;
    logic [SB-1:0]            r_rdata;

    logic [SB-1:0]            mem [MAX_SLOTS];
    logic                     mem_we, mem_re;
    logic [AW-1:0]            mem_waddr, mem_raddr;
    logic [SB-1:0]            mem_wdata;

    logic [CMPW-1:0]          req_slot;
    logic                     req_in_range;
    logic [SIW-1:0]           bit_pos;
    logic [SB-1:0]            bit_mask;
    logic [SIW-1:0]           zero_pos;
    logic [CW-1:0]            next_i;
    logic [CW-1:0]            count_m1;
    logic [AW+SIW+BIW-1:0]    found_wide;
    logic                     out_free;

    // Position of the lowest zero bit, found by halving the word six times.
    function automatic logic [SIW-1:0] first_zero(input logic [SB-1:0] s);
        logic [SB-1:0]  v;
        logic [SIW-1:0] p;
        v = ~s;
        p = '0;
        for (int k = SIW - 1; k >= 0; k--) begin
            if ((v & ((SB'(1) << (1 << k)) - SB'(1))) == '0) begin
                p[k] = 1'b1;
                v    = v >> (1 << k);
            end
        end
        return p;
    endfunction

    assign req_slot     = CMPW'(r_req.bit_index[BIW-1:SIW]);
    assign req_in_range = req_slot < CMPW'(r_count);
    assign bit_pos      = r_req.bit_index[SIW-1:0];
    assign bit_mask     = SB'(1) << bit_pos;
    assign zero_pos     = first_zero(r_rdata);
    assign next_i       = CW'(r_i) + CW'(1);
    assign count_m1     = r_count - CW'(1);
    assign found_wide   = {{BIW{1'b0}}, r_i, zero_pos};
    assign out_free     = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_req       = r_req;
        n_i         = r_i;
        n_removed   = r_removed;
        n_res       = r_res;
        n_out_item  = r_out_item;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = '0;
        mem_raddr   = '0;
        mem_wdata   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_item;
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_res   = '0;
                n_state = S_DONE;
                case (r_req.kind)
                    alloc_bmp_pkg::KIND_WRITE, alloc_bmp_pkg::KIND_READ: begin
                        if (req_in_range) begin
                            mem_re    = 1'b1;
                            mem_raddr = req_slot[AW-1:0];
                            n_state   = S_RW;
                        end else begin
                            n_res.status = 1'b1;
                        end
                    end
                    alloc_bmp_pkg::KIND_FIND: begin
                        if (r_count != '0) begin
                            mem_re    = 1'b1;
                            mem_raddr = '0;
                            n_i       = '0;
                            n_state   = S_FIND;
                        end
                    end
                    alloc_bmp_pkg::KIND_EXPAND: begin
                        if (r_count == FULL_COUNT) begin
                            n_res.status = 1'b1;
                        end else begin
                            mem_we             = 1'b1;
                            mem_waddr          = r_count[AW-1:0];
                            mem_wdata          = alloc_bmp_pkg::SLOT_ONES;
                            n_count            = r_count + CW'(1);
                            n_res.bits_changed = CHW'(SB);
                        end
                    end
                    alloc_bmp_pkg::KIND_COMPACT: begin
                        n_removed = '0;
                        if (r_count != '0) begin
                            mem_re    = 1'b1;
                            mem_raddr = count_m1[AW-1:0];
                            n_i       = count_m1[AW-1:0];
                            n_state   = S_COMPACT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RW: begin
                // Writes land well before the next item can issue its read.
                if (r_req.kind == alloc_bmp_pkg::KIND_WRITE) begin
                    mem_we    = 1'b1;
                    mem_waddr = req_slot[AW-1:0];
                    mem_wdata = r_req.set_value ? (r_rdata | bit_mask)
                                                : (r_rdata & ~bit_mask);
                end else begin
                    n_res.bit_value = r_rdata[bit_pos];
                end
                n_state = S_DONE;
            end
            S_FIND: begin
                // Data for slot r_i is here; the read of the following slot goes out now.
                if (r_rdata != alloc_bmp_pkg::SLOT_ONES) begin
                    n_res.found       = 1'b1;
                    n_res.found_index = found_wide[BIW-1:0];
                    n_state           = S_DONE;
                end else if (next_i >= r_count) begin
                    n_state = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = next_i[AW-1:0];
                    n_i       = next_i[AW-1:0];
                end
            end
            S_COMPACT: begin
                if (r_rdata == '0) begin
                    n_count   = r_count - CW'(1);
                    n_removed = r_removed + CHW'(SB);
                    if (r_i == '0) begin
                        n_res.bits_changed = r_removed + CHW'(SB);
                        n_state            = S_DONE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_i - AW'(1);
                        n_i       = r_i - AW'(1);
                    end
                end else begin
                    n_res.bits_changed = r_removed;
                    n_state            = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_item  = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_i        <= n_i;
        r_removed  <= n_removed;
        r_res      <= n_res;
        r_out_item <= n_out_item;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

endmodule

[bench/tb.sv]
// Testbench for the allocation bitmap: directed and random requests checked against a predictor.
module tb;
    import alloc_bmp_pkg::*;

    localparam logic [2:0] KIND_UNUSED_FIRST = 3'(KIND_COMPACT) + 3'd1;
    localparam logic [2:0] KIND_UNUSED_LAST  = '1;
    localparam int         QUEUE_AHEAD       = 8;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    allocation_bitmap_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #6 i_clk = ~i_clk;

    // Shadow of the bitmap as the block should hold it after every accepted item.
    logic [SLOT_BITS-1:0] slot_mem [MAX_SLOTS_DEF];
    int                   slots_used = 0;

    t_in_item  pending_reqs [$];
    t_out_item expected_results [$];
    logic      req_taken      = 1'b0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        hold_request   = 0;
    int        hold_left      = 0;
    int        mismatch_count = 0;

    function automatic t_out_item bitmap_apply(t_in_item req);
        t_out_item res;
        int        slot;
        int        pos;
        int        s;
        int        b;
        logic      done;
        res  = '0;
        slot = req.bit_index / SLOT_BITS;
        pos  = req.bit_index % SLOT_BITS;
        done = 1'b0;
        case (req.kind)
            KIND_WRITE: begin
                if (slot >= slots_used)
                    res.status = 1'b1;
                else
                    slot_mem[slot][pos] = req.set_value;
            end
            KIND_READ: begin
                if (slot >= slots_used)
                    res.status = 1'b1;
                else
                    res.bit_value = slot_mem[slot][pos];
            end
            KIND_FIND: begin
                for (s = 0; s < slots_used; s++) begin
                    for (b = 0; b < SLOT_BITS; b++) begin
                        if (!done && !slot_mem[s][b]) begin
                            res.found       = 1'b1;
                            res.found_index = BIT_IDX_W'(s * SLOT_BITS + b);
                            done            = 1'b1;
                        end
                    end
                end
            end
            KIND_EXPAND: begin
                if (slots_used >= MAX_SLOTS_DEF) begin
                    res.status = 1'b1;
                end else begin
                    slot_mem[slots_used] = SLOT_ONES;
                    slots_used++;
                    res.bits_changed = CHG_W'(SLOT_BITS);
                end
            end
            KIND_COMPACT: begin
                while (slots_used > 0 && slot_mem[slots_used-1] == '0) begin
                    slots_used--;
                    res.bits_changed = res.bits_changed + CHG_W'(SLOT_BITS);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Driver: a new item is offered only once the previous one was taken or none was up.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || req_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_item  <= pending_reqs[0];
            end else begin
                in_valid <= 1'b0;
            end
        end
        req_taken <= 1'b0;
    end

    // Receiver stall, with an optional long hold-off loaded from the stimulus.
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Monitor: checks results against the oldest expectation, then records accepted items.
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: bv=%0d fnd=%0d fidx=%0d chg=%0d st=%0d",
                             out_item.bit_value, out_item.found, out_item.found_index,
                             out_item.bits_changed, out_item.status);
            end else begin
                want = expected_results.pop_front();
                if (out_item.bit_value !== want.bit_value || out_item.found !== want.found ||
                    out_item.found_index !== want.found_index ||
                    out_item.bits_changed !== want.bits_changed ||
                    out_item.status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected bv=%0d fnd=%0d fidx=%0d chg=%0d st=%0d,",
                                  " got bv=%0d fnd=%0d fidx=%0d chg=%0d st=%0d"},
                                 want.bit_value, want.found, want.found_index,
                                 want.bits_changed, want.status,
                                 out_item.bit_value, out_item.found, out_item.found_index,
                                 out_item.bits_changed, out_item.status);
                end
            end
        end
        if (i_rst_n && in_valid && !in_stall) begin
            expected_results.push_back(bitmap_apply(in_item));
            void'(pending_reqs.pop_front());
            req_taken <= 1'b1;
        end
    end

    task automatic queue_req(logic [2:0] kind, int idx, logic val);
        t_in_item r;
        while (pending_reqs.size() >= QUEUE_AHEAD)
            @(posedge i_clk);
        r.kind      = kind;
        r.bit_index = BIT_IDX_W'(idx);
        r.set_value = val;
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // An index inside the slots in use; anywhere when the store is empty.
    function automatic int pick_index();
        if (slots_used == 0)
            return $urandom_range(0, 4095);
        return $urandom_range(0, slots_used * SLOT_BITS - 1);
    endfunction

    task automatic random_req();
        int r;
        r = $urandom_range(0, 99);
        if (r < 14)
            queue_req(KIND_EXPAND, $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
        else if (r < 34)
            queue_req(KIND_READ, pick_index(), 1'($urandom_range(0, 1)));
        else if (r < 62)
            queue_req(KIND_WRITE, pick_index(), $urandom_range(0, 99) < 70);
        else if (r < 76)
            queue_req(KIND_FIND, $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
        else if (r < 84)
            queue_req(KIND_COMPACT, $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
        else if (r < 88)
            queue_req(3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST)),
                      $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
        else if (r < 94)
            queue_req(KIND_READ, $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
        else
            queue_req(KIND_WRITE, $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
    endtask

    // Sets zero bits below a random slot, at most 48 of them, so that the next search lands deep in the store.
    task automatic heal_low_slots();
        int limit_slot;
        int s;
        int b;
        int n;
        drain();
        limit_slot = $urandom_range(0, slots_used);
        n = 0;
        for (s = 0; s < limit_slot; s++) begin
            for (b = 0; b < SLOT_BITS; b++) begin
                if (!slot_mem[s][b] && n < 48) begin
                    queue_req(KIND_WRITE, s * SLOT_BITS + b, 1'b1);
                    n++;
                end
            end
        end
        queue_req(KIND_FIND, 0, 1'b0);
    endtask

    // Clears the top slots bit by bit in random order, then compacts. Now and then one
    // bit is left set so that the compact finds nothing to drop.
    task automatic clear_top_slots(int count);
        int   order [SLOT_BITS];
        int   top;
        int   k;
        int   i;
        int   j;
        int   tmp;
        int   skip_at;
        drain();
        skip_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, SLOT_BITS - 1) : -1;
        for (k = 0; k < count; k++) begin
            if (slots_used - k > 0) begin
                top = slots_used - 1 - k;
                for (i = 0; i < SLOT_BITS; i++)
                    order[i] = i;
                for (i = SLOT_BITS - 1; i > 0; i--) begin
                    j        = $urandom_range(0, i);
                    tmp      = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                for (i = 0; i < SLOT_BITS; i++) begin
                    if (!(k == 0 && i == skip_at))
                        queue_req(KIND_WRITE, top * SLOT_BITS + order[i], 1'b0);
                    if (i == 3)
                        queue_req(KIND_FIND, $urandom_range(0, 4095), 1'b1);
                end
            end
        end
        queue_req(KIND_COMPACT, 0, 1'b0);
    endtask

    initial begin : stimulus
        int phase;
        int n;
        int clear_at;
        int grow;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty store first: accesses out of range, search finds nothing, compact drops nothing; then one slot.
        queue_req(KIND_READ, 0, 1'b0);
        queue_req(KIND_WRITE, 4095, 1'b1);
        queue_req(KIND_FIND, 4095, 1'b1);
        queue_req(KIND_COMPACT, 0, 1'b0);
        queue_req(KIND_EXPAND, 0, 1'b0);
        queue_req(KIND_READ, 0, 1'b0);
        queue_req(KIND_READ, 63, 1'b1);
        queue_req(KIND_READ, 64, 1'b0);
        queue_req(KIND_WRITE, 64, 1'b0);
        queue_req(KIND_FIND, 0, 1'b0);
        queue_req(KIND_WRITE, 0, 1'b0);
        queue_req(KIND_FIND, 0, 1'b0);
        queue_req(KIND_WRITE, 63, 1'b0);
        queue_req(KIND_WRITE, 0, 1'b1);
        queue_req(KIND_READ, 63, 1'b0);
        queue_req(KIND_FIND, 0, 1'b0);
        queue_req(KIND_EXPAND, 4095, 1'b1);
        queue_req(KIND_WRITE, 127, 1'b0);
        queue_req(KIND_FIND, 0, 1'b0);
        queue_req(KIND_COMPACT, 4095, 1'b1);
        queue_req(KIND_UNUSED_FIRST, 4095, 1'b1);
        queue_req(KIND_UNUSED_FIRST + 3'd1, 0, 1'b0);
        queue_req(KIND_UNUSED_LAST, 4095, 1'b1);

        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 63 : (phase == 3) ? 29 : 0;
            recv_stall_pct = (phase == 2) ? 63 : (phase == 3) ? 29 : 0;
            if (phase == 0)
                hold_request = 300;
            if (phase == 3) begin
                // Fill the store and push past it so expand reports full.
                drain();
                grow = MAX_SLOTS_DEF - slots_used + 2;
                for (n = 0; n < grow; n++)
                    queue_req(KIND_EXPAND, 0, 1'b0);
            end
            clear_at = $urandom_range(10, 120);
            for (n = 0; n < 140; n++) begin
                if (n == clear_at) begin
                    heal_low_slots();
                    clear_top_slots((phase == 2) ? 2 : 1);
                end
                random_req();
            end
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin : watchdog
        #(12 * 1000000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/core/alloc_bmp_pkg.sv
rtl/core/allocation_bitmap_top.sv
bench/tb.sv
